FILE: design/ascii_decimal_to_fixed_parser_assert.svh
// Assertion macros shared by the parser RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ASCII_DECIMAL_TO_FIXED_PARSER_ASSERT_SVH
`define ASCII_DECIMAL_TO_FIXED_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/adfp_pkg.sv
// Package for the ASCII decimal to fixed point parser: sizes, codes and types.
// No dependencies; used by adfp_parse_step and ascii_decimal_to_fixed_parser.
`default_nettype none

package adfp_pkg;

    // Text and fixed point format.
    localparam int MAX_TEXT    = 31;
    localparam int FRAC_DIGITS = 4;

    localparam int BC_W    = $clog2(MAX_TEXT + 1);
    localparam int FC_W    = $clog2(FRAC_DIGITS + 1);
    localparam int ACC_W   = 24;
    // Room for acc * 10 plus one weighted digit before saturation.
    localparam int SUM_W   = ACC_W + 4;
    localparam int STATUS_W = 3;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 2'd2;

    localparam logic [ACC_W-1:0] MIN_RESET     = 24'd0;
    localparam logic [ACC_W-1:0] MAX_RESET     = 24'd100000;
    localparam logic [ACC_W-1:0] DEFAULT_RESET = 24'd10000;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_INT   = 3'd1,
        PH_FRAC  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_END   = 3'd4,
        PH_BAD   = 3'd5
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_DIGIT  = 3'd1,
        ST_STRAY     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_XFER_FAIL = 3'd4
    } status_t;

    // Parse state carried from one byte to the next.
    typedef struct packed {
        phase_t            phase;
        logic [ACC_W-1:0]  acc;
        logic [FC_W-1:0]   frac_cnt;
        logic              seen_digit;
        logic              overflowed;
        logic [BC_W-1:0]   byte_cnt;
    } parse_state_t;

    // Power of ten, for constant arguments only.
    function automatic logic [SUM_W-1:0] ten_pow(input int n);
        logic [SUM_W-1:0] v;
        v = SUM_W'(1);
        for (int i = 0; i < n; i++) begin
            v = v * SUM_W'(10);
        end
        return v;
    endfunction

    // Weight of the fraction digit at the given position (0 is tenths).
    function automatic logic [SUM_W-1:0] frac_weight(input logic [FC_W-1:0] fc);
        logic [SUM_W-1:0] w;
        w = '0;
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            if (fc == FC_W'(i)) begin
                w = ten_pow(FRAC_DIGITS - 1 - i);
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/adfp_parse_step.sv
// One byte step of the decimal parser: next phase, accumulator and counters.
// Pure combinational logic; depends on adfp_pkg.
`default_nettype none

module adfp_parse_step (
    input  wire adfp_pkg::parse_state_t cur,
    input  wire logic [7:0]             text_byte,
    output adfp_pkg::parse_state_t      nxt
);

    logic                         take;
    logic                         active;
    logic                         is_digit;
    logic                         is_blank;
    logic                         is_point;
    logic                         is_nul;
    logic [3:0]                   digit;
    logic                         int_add;
    logic                         frac_add;
    logic [adfp_pkg::SUM_W-1:0]   sum;
    adfp_pkg::phase_t             phase_next;

    // Character classes.
    assign is_digit = (text_byte >= adfp_pkg::CH_ZERO) && (text_byte <= adfp_pkg::CH_NINE);
    assign is_blank = (text_byte == adfp_pkg::CH_SPACE) || (text_byte == adfp_pkg::CH_CR)
                   || (text_byte == adfp_pkg::CH_LF) || (text_byte == adfp_pkg::CH_TAB);
    assign is_point = (text_byte == adfp_pkg::CH_POINT);
    assign is_nul   = (text_byte == adfp_pkg::CH_NUL);
    assign digit    = 4'(text_byte - adfp_pkg::CH_ZERO);

    // Only the first MAX_TEXT bytes count; a finished or failed parse ignores the rest.
    assign take   = (cur.byte_cnt < adfp_pkg::BC_W'(adfp_pkg::MAX_TEXT));
    assign active = take && (cur.phase != adfp_pkg::PH_END)
                 && (cur.phase != adfp_pkg::PH_BAD) && !is_nul;

    // Next phase.
    always_comb
    begin
        phase_next = cur.phase;
        if (take && (cur.phase != adfp_pkg::PH_END) && (cur.phase != adfp_pkg::PH_BAD))
        begin
            if (is_nul)
            begin
                phase_next = adfp_pkg::PH_END;
            end
            else
            begin
                unique case (cur.phase)
                    adfp_pkg::PH_LEAD, adfp_pkg::PH_INT:
                    begin
                        if (is_digit)
                            phase_next = adfp_pkg::PH_INT;
                        else if (is_point)
                            phase_next = adfp_pkg::PH_FRAC;
                        else if (is_blank)
                            phase_next = (cur.phase == adfp_pkg::PH_INT) ?
                                         adfp_pkg::PH_TRAIL : adfp_pkg::PH_LEAD;
                        else
                            phase_next = adfp_pkg::PH_BAD;
                    end
                    adfp_pkg::PH_FRAC:
                    begin
                        if (is_blank)
                            phase_next = adfp_pkg::PH_TRAIL;
                        else if (!is_digit)
                            phase_next = adfp_pkg::PH_BAD;
                    end
                    default:
                    begin
                        if (!is_blank)
                            phase_next = adfp_pkg::PH_BAD;
                    end
                endcase
            end
        end
    end

    // Digit accumulation: integer digits shift the value up one decade,
    // fraction digits add at their own weight.
    assign int_add  = active && is_digit
                   && ((cur.phase == adfp_pkg::PH_LEAD) || (cur.phase == adfp_pkg::PH_INT));
    assign frac_add = active && is_digit && (cur.phase == adfp_pkg::PH_FRAC)
                   && (cur.frac_cnt < adfp_pkg::FC_W'(adfp_pkg::FRAC_DIGITS));

    always_comb
    begin
        if (int_add)
            sum = adfp_pkg::SUM_W'(cur.acc) * adfp_pkg::SUM_W'(10)
                + adfp_pkg::SUM_W'(digit) * adfp_pkg::ten_pow(adfp_pkg::FRAC_DIGITS);
        else
            sum = adfp_pkg::SUM_W'(cur.acc)
                + adfp_pkg::SUM_W'(digit) * adfp_pkg::frac_weight(cur.frac_cnt);
    end

    // Datapath outputs.
    always_comb
    begin
        nxt            = cur;
        nxt.phase      = phase_next;
        if (take)
            nxt.byte_cnt = cur.byte_cnt + adfp_pkg::BC_W'(1);
        if (active && is_digit && ((cur.phase == adfp_pkg::PH_LEAD)
            || (cur.phase == adfp_pkg::PH_INT) || (cur.phase == adfp_pkg::PH_FRAC)))
            nxt.seen_digit = 1'b1;
        if (frac_add)
            nxt.frac_cnt = cur.frac_cnt + adfp_pkg::FC_W'(1);
        if (int_add || frac_add)
        begin
            if (sum > adfp_pkg::SUM_W'(adfp_pkg::ACC_MAX))
            begin
                nxt.acc        = adfp_pkg::ACC_MAX;
                nxt.overflowed = 1'b1;
            end
            else
            begin
                nxt.acc = sum[adfp_pkg::ACC_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/ascii_decimal_to_fixed_parser.sv
// Top level of the ASCII decimal to fixed point parser.
// Depends on adfp_pkg, adfp_parse_step and ascii_decimal_to_fixed_parser_assert.svh.
//
//   Channel  | Handshake             | Carries
//   ---------+-----------------------+------------------------------------------
//   in       | in_valid / in_stall   | text_byte, last, transfer_ok
//   out      | out_valid / out_stall | status, parsed_value, layer_value, held_valid
//   cfg      | cfg_write             | cfg_index, cfg_data
//
// One byte is accepted every cycle unless in_stall is high; a byte is held in the input
// register, where the parse step updates the state, and a last byte's result is then
// written to the output register.
// Reset clears the parse state, the held value and both valid flags.
// A stalled result holds the output register; a last byte then waits in the input
// register and in_stall rises. Bytes that are not last never wait.
`default_nettype none

module ascii_decimal_to_fixed_parser (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [7:0]                            text_byte,
    input  wire logic                                  last,
    input  wire logic                                  transfer_ok,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [adfp_pkg::STATUS_W-1:0]              status,
    output logic [adfp_pkg::ACC_W-1:0]                 parsed_value,
    output logic [adfp_pkg::ACC_W-1:0]                 layer_value,
    output logic                                       held_valid,
    input  wire logic                                  cfg_write,
    input  wire logic [adfp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [adfp_pkg::ACC_W-1:0]            cfg_data
);

`include "ascii_decimal_to_fixed_parser_assert.svh"

    logic [adfp_pkg::ACC_W-1:0]   min_reg;
    logic [adfp_pkg::ACC_W-1:0]   max_reg;
    logic [adfp_pkg::ACC_W-1:0]   default_reg;

    logic                         s1_valid_reg;
    logic [7:0]                   s1_byte_reg;
    logic                         s1_last_reg;
    logic                         s1_ok_reg;

    adfp_pkg::parse_state_t       state_reg;
    adfp_pkg::parse_state_t       step_state;
    adfp_pkg::parse_state_t       state_next;

    logic [adfp_pkg::ACC_W-1:0]   held_value_reg;
    logic                         held_flag_reg;
    logic [adfp_pkg::ACC_W-1:0]   held_value_next;
    logic                         held_flag_next;

    logic                         out_valid_reg;
    adfp_pkg::status_t            out_status_reg;
    logic [adfp_pkg::ACC_W-1:0]   out_parsed_reg;
    logic [adfp_pkg::ACC_W-1:0]   out_layer_reg;
    logic                         out_held_reg;

    logic                         in_accept;
    logic                         out_free;
    logic                         s1_adv;
    logic                         s1_done;
    adfp_pkg::status_t            status_next;
    logic [adfp_pkg::ACC_W-1:0]   layer_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= adfp_pkg::MIN_RESET;
            max_reg     <= adfp_pkg::MAX_RESET;
            default_reg <= adfp_pkg::DEFAULT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == adfp_pkg::CFG_MIN)
                min_reg <= cfg_data;
            if (cfg_index == adfp_pkg::CFG_MAX)
                max_reg <= cfg_data;
            if (cfg_index == adfp_pkg::CFG_DEFAULT)
                default_reg <= cfg_data;
        end
    end

    // Handshake: a byte leaves the input register unless it is a last byte
    // and the output register is still occupied.
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || out_free);
    assign s1_done   = s1_adv && s1_last_reg;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= last;
            s1_ok_reg   <= transfer_ok;
        end
    end

    // Parse step on the registered byte.
    adfp_parse_step u_step (
        .cur       (state_reg),
        .text_byte (s1_byte_reg),
        .nxt       (step_state)
    );

    // Judge the body on its last byte.
    always_comb
    begin
        priority if (!s1_ok_reg)
            status_next = adfp_pkg::ST_XFER_FAIL;
        else if (!step_state.seen_digit)
            status_next = adfp_pkg::ST_NO_DIGIT;
        else if (step_state.phase == adfp_pkg::PH_BAD)
            status_next = adfp_pkg::ST_STRAY;
        else if (step_state.overflowed || (step_state.acc < min_reg)
                 || (step_state.acc > max_reg))
            status_next = adfp_pkg::ST_RANGE;
        else
            status_next = adfp_pkg::ST_OK;
    end

    // Held value and next parse state; a finished body restarts the parse.
    always_comb
    begin
        held_value_next = held_value_reg;
        held_flag_next  = held_flag_reg;
        state_next      = state_reg;
        if (s1_adv)
        begin
            state_next = step_state;
            if (s1_last_reg)
            begin
                state_next = '{phase: adfp_pkg::PH_LEAD, default: '0};
                if (status_next == adfp_pkg::ST_OK)
                begin
                    held_value_next = step_state.acc;
                    held_flag_next  = 1'b1;
                end
            end
        end
        layer_next = held_flag_next ? held_value_next : default_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '{phase: adfp_pkg::PH_LEAD, default: '0};
            held_value_reg <= '0;
            held_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_value_reg <= held_value_next;
            held_flag_reg  <= held_flag_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_done)
        begin
            out_status_reg <= status_next;
            out_parsed_reg <= step_state.acc;
            out_layer_reg  <= layer_next;
            out_held_reg   <= held_flag_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign parsed_value = out_parsed_reg;
    assign layer_value  = out_layer_reg;
    assign held_valid   = out_held_reg;

    // Checks on the parse and result logic.
    `ADFP_ASSERT_NOW(a_sat_acc, state_reg.overflowed, state_reg.acc == adfp_pkg::ACC_MAX, "overflowed accumulator is not saturated")
    `ADFP_ASSERT_NOW(a_byte_cnt, 1'b1, state_reg.byte_cnt <= adfp_pkg::BC_W'(adfp_pkg::MAX_TEXT), "byte count past text limit")
    `ADFP_ASSERT_NOW(a_frac_cnt, 1'b1, state_reg.frac_cnt <= adfp_pkg::FC_W'(adfp_pkg::FRAC_DIGITS), "fraction count past digit limit")
    `ADFP_ASSERT_NEXT(a_clear, s1_done, (state_reg.byte_cnt == '0) && (state_reg.phase == adfp_pkg::PH_LEAD), "parse state not cleared after last byte")
    `ADFP_ASSERT_NOW(a_ok_held, out_valid_reg && (out_status_reg == adfp_pkg::ST_OK), out_held_reg && (out_layer_reg == out_parsed_reg), "accepted value not held")
    `ADFP_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_reg && s1_last_reg && out_valid_reg, "input stalled without a waiting result")

endmodule

`default_nettype wire

FILE: bench/adfp_parse_checker.sv
`timescale 1ns / 100ps
// Result checker for the ASCII decimal parser bench: follows the byte channel, the
// result channel and the register port, predicts every result and compares it.
// Depends on adfp_pkg for widths, phase and status codes and register indexes.
module adfp_parse_checker
    import adfp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 last,
    input  wire logic                 transfer_ok,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [STATUS_W-1:0]  status,
    input  wire logic [ACC_W-1:0]     parsed_value,
    input  wire logic [ACC_W-1:0]     layer_value,
    input  wire logic                 held_valid,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ACC_W-1:0]     cfg_data,
    output int                        mismatch_count,
    output int                        results_checked,
    output int                        outstanding
);

    localparam int UNIT_SCALE = 10 ** FRAC_DIGITS;

    // One result as it appears on the output channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ACC_W-1:0]    parsed;
        logic [ACC_W-1:0]    layer;
        logic                held;
    } reading_t;

    // Limits and fallback as last written through the register port.
    logic [ACC_W-1:0] lo_limit;
    logic [ACC_W-1:0] hi_limit;
    logic [ACC_W-1:0] fallback;

    // Scan state of the body in progress, and the value kept across bodies.
    phase_t           scan_phase;
    logic [ACC_W-1:0] total;
    int               frac_seen;
    logic             got_digit;
    logic             saturated;
    int               chars_seen;
    logic [ACC_W-1:0] kept_value;
    logic             kept;

    reading_t expected_q[$];

    task automatic restart_scan();
        scan_phase = PH_LEAD;
        total      = '0;
        frac_seen  = 0;
        got_digit  = 1'b0;
        saturated  = 1'b0;
        chars_seen = 0;
    endtask

    // Adds into the running total, pinning it at all ones on overflow.
    task automatic accumulate(input logic [31:0] sum);
        if (sum > 32'(ACC_MAX)) begin
            total     = ACC_MAX;
            saturated = 1'b1;
        end
        else begin
            total = sum[ACC_W-1:0];
        end
    endtask

    // Moves the scan forward by one character of the body.
    task automatic scan_char(input logic [7:0] c);
        logic        is_digit;
        logic        is_space;
        logic [31:0] digit;
        int          weight;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        digit    = is_digit ? {24'd0, c - CH_ZERO} : 32'd0;
        if (scan_phase == PH_END || scan_phase == PH_BAD)
            return;
        // A NUL closes the text; the rest of the body is dead.
        if (c == CH_NUL) begin
            scan_phase = PH_END;
            return;
        end
        case (scan_phase)
            PH_LEAD, PH_INT:
            begin
                if (is_digit) begin
                    got_digit  = 1'b1;
                    scan_phase = PH_INT;
                    accumulate(32'(total) * 10 + digit * UNIT_SCALE);
                end
                else if (c == CH_POINT)
                    scan_phase = PH_FRAC;
                else if (is_space)
                    scan_phase = (scan_phase == PH_INT) ? PH_TRAIL : PH_LEAD;
                else
                    scan_phase = PH_BAD;
            end
            PH_FRAC:
            begin
                if (is_digit) begin
                    got_digit = 1'b1;
                    // Digits past the last fraction place are legal but dropped.
                    if (frac_seen < FRAC_DIGITS) begin
                        weight = UNIT_SCALE;
                        for (int k = 0; k <= frac_seen; k++)
                            weight = weight / 10;
                        accumulate(32'(total) + digit * weight);
                        frac_seen++;
                    end
                end
                else if (is_space)
                    scan_phase = PH_TRAIL;
                else
                    scan_phase = PH_BAD;
            end
            default:
            begin
                if (!is_space)
                    scan_phase = PH_BAD;
            end
        endcase
    endtask

    // Field order in the report is status/value/layer/held.
    task automatic note_mismatch(input string what, input reading_t want, input reading_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b", $time, what,
                want.status, want.parsed, want.layer, want.held,
                got.status, got.parsed, got.layer, got.held);
    endtask

    always @(posedge clk or negedge rst_n) begin : follow
        reading_t want;
        reading_t got;
        status_t  verdict;
        if (!rst_n) begin
            lo_limit        = 24'd0;
            hi_limit        = 24'd100000;
            fallback        = 24'd10000;
            kept_value      = '0;
            kept            = 1'b0;
            mismatch_count  = 0;
            results_checked = 0;
            expected_q.delete();
            restart_scan();
            outstanding <= 0;
        end
        else begin
            // Register writes only come while the block is idle.
            if (cfg_write) begin
                case (cfg_index)
                    CFG_MIN:     lo_limit = cfg_data;
                    CFG_MAX:     hi_limit = cfg_data;
                    CFG_DEFAULT: fallback = cfg_data;
                    default:     ;
                endcase
            end

            // Byte request: only the head of a body is scanned, the last mark always counts.
            if (in_valid && !in_stall) begin
                if (chars_seen < MAX_TEXT) begin
                    scan_char(text_byte);
                    chars_seen++;
                end
                if (last) begin
                    if (!transfer_ok)
                        verdict = ST_XFER_FAIL;
                    else if (!got_digit)
                        verdict = ST_NO_DIGIT;
                    else if (scan_phase == PH_BAD)
                        verdict = ST_STRAY;
                    else if (saturated || total < lo_limit || total > hi_limit)
                        verdict = ST_RANGE;
                    else
                        verdict = ST_OK;
                    if (verdict == ST_OK) begin
                        kept_value = total;
                        kept       = 1'b1;
                    end
                    want.status = verdict;
                    want.parsed = total;
                    want.layer  = kept ? kept_value : fallback;
                    want.held   = kept;
                    expected_q.push_back(want);
                    restart_scan();
                end
            end

            // Result request: compare against the oldest prediction.
            if (out_valid && !out_stall) begin
                got.status = status;
                got.parsed = parsed_value;
                got.layer  = layer_value;
                got.held   = held_valid;
                if (expected_q.size() == 0) begin
                    want = '0;
                    note_mismatch("result with nothing expected", want, got);
                end
                else begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (got !== want)
                        note_mismatch("result mismatch", want, got);
                end
            end

            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: bench/tb_ascii_decimal_to_fixed_parser.sv
`timescale 1ns / 100ps
// Bench top for ascii_decimal_to_fixed_parser: clock, reset, text bodies, limit
// settings and the verdict. Depends on adfp_pkg, the RTL and adfp_parse_checker.
module tb_ascii_decimal_to_fixed_parser;
    import adfp_pkg::*;

    localparam int LONG_HOLD         = 200;
    localparam int SETTLE_CYCLES     = 8;
    localparam int BYTES_PER_SETTING = 135;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [7:0]           text_byte   = '0;
    logic                 last        = 1'b0;
    logic                 transfer_ok = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [ACC_W-1:0]     parsed_value;
    logic [ACC_W-1:0]     layer_value;
    logic                 held_valid;
    logic                 cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_MIN;
    logic [ACC_W-1:0]     cfg_data    = '0;

    int mismatch_count;
    int results_checked;
    int outstanding;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_wanted   = 1'b0;
    logic hold_served   = 1'b0;
    int   bodies_sent   = 0;
    int   bytes_sent    = 0;

    logic [7:0] body_q[$];

    ascii_decimal_to_fixed_parser dut (.*);

    adfp_parse_checker checker_i (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_wanted && !hold_served) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served = 1'b1;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Offers one byte and holds it until the block takes it.
    task automatic offer_byte(input logic [7:0] c, input logic is_last, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= c;
        last        <= is_last;
        transfer_ok <= is_last ? ok : 1'($urandom_range(1));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_body(input logic ok);
        foreach (body_q[i])
            offer_byte(body_q[i], i == body_q.size() - 1, ok);
        bodies_sent++;
    endtask

    task automatic fill_text(input string s);
        body_q.delete();
        for (int i = 0; i < s.len(); i++)
            body_q.push_back(s[i]);
    endtask

    task automatic send_text(input string s, input logic ok);
        fill_text(s);
        send_body(ok);
    endtask

    // A number body (it may hold no digit): blanks, integer digits, maybe a point and fraction, blanks.
    task automatic build_number();
        int roll;
        int n_int;
        body_q.delete();
        repeat ($urandom_range(2))
            body_q.push_back(pick_blank());
        roll  = $urandom_range(99);
        n_int = (roll < 6) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(4, 9);
        repeat (n_int)
            body_q.push_back(pick_digit());
        if ($urandom_range(2) != 0) begin
            body_q.push_back(CH_POINT);
            repeat ($urandom_range(6))
                body_q.push_back(pick_digit());
        end
        repeat ($urandom_range(2))
            body_q.push_back(pick_blank());
        if (body_q.size() == 0)
            body_q.push_back(pick_blank());
    endtask

    // Mostly clean numbers; the rest are corrupted, cut by a NUL, pure noise or overlong.
    task automatic build_body();
        int roll;
        int spot;
        int target;
        roll = $urandom_range(99);
        build_number();
        if (roll < 80)
            return;
        if (roll < 87) begin
            body_q[$urandom_range(body_q.size() - 1)] = 8'($urandom);
        end
        else if (roll < 92) begin
            spot = $urandom_range(body_q.size());
            body_q.insert(spot, CH_NUL);
            repeat ($urandom_range(1, 3))
                body_q.push_back(8'($urandom));
        end
        else if (roll < 96) begin
            body_q.delete();
            repeat ($urandom_range(1, 6))
                body_q.push_back(8'($urandom));
        end
        else begin
            target = $urandom_range(28, 40);
            while (body_q.size() < target)
                body_q.push_front(pick_blank());
        end
    endtask

    task automatic send_random_body();
        build_body();
        send_body($urandom_range(99) < 92);
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_limits(input logic [ACC_W-1:0] lo, input logic [ACC_W-1:0] hi,
                               input logic [ACC_W-1:0] dflt);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_DEFAULT;
        cfg_data  <= dflt;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial begin : stimulus
        int goal;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed bodies under the reset limits (0 to 10.0, default 1.0).
        send_idle_pct = 13;
        recv_idle_pct = 46;
        send_text("x", 1'b1);
        send_text("7.25", 1'b1);
        send_text(".", 1'b1);
        send_text("1x", 1'b1);
        send_text("12", 1'b1);
        send_text("5", 1'b0);
        fill_text(" 3.123456");
        body_q.insert(1, CH_TAB);
        body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
        send_body(1'b1);
        fill_text("1zz");
        body_q.insert(1, CH_NUL);
        send_body(1'b1);
        send_text("99999999", 1'b1);
        fill_text("1");
        repeat (34) body_q.push_back(CH_SPACE);
        body_q.push_back(8'h78);
        send_body(1'b1);
        fill_text("4");
        body_q.push_back(8'hFF);
        send_body(1'b1);
        fill_text(" ");
        body_q.push_back(8'h80);
        send_body(1'b1);
        send_text("0", 1'b1);
        send_text("10", 1'b1);
        send_text("10.0001", 1'b1);
        settle();

        // Random bodies over several limit settings and idling patterns.
        for (int setting = 0; setting < 6; setting++) begin
            send_idle_pct = (setting < 2) ? 13 : (setting < 4) ? 46 : 0;
            recv_idle_pct = (setting < 2) ? 46 : (setting < 4) ? 13 : 0;
            case (setting)
                0: load_limits(24'd0, ACC_MAX, 24'd0);
                1: load_limits(24'($urandom_range(20000)), 24'($urandom_range(50000, 400000)),
                               24'($urandom));
                2: load_limits(24'd50000, 24'd40000, ACC_MAX);
                3: load_limits(24'($urandom_range(100000)), 24'($urandom_range(100000, 2000000)),
                               24'($urandom));
                4: load_limits(ACC_MAX, ACC_MAX, 24'($urandom));
                default: load_limits(24'd0, 24'd0, ACC_MAX);
            endcase

            // Let the result side hold off long enough that last bytes back up.
            if (setting == 0) begin
                hold_wanted = 1'b1;
                while (!hold_served)
                    send_random_body();
                hold_wanted = 1'b0;
            end
            // The largest value that fits without saturating.
            if (setting == 4)
                send_text("1677.7215", 1'b1);

            goal = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < goal)
                send_random_body();
            settle();
        end

        $display("Sent %0d text bodies (%0d bytes) over six limit settings and three idling mixes;",
            bodies_sent, bytes_sent);
        $display("%0d results compared, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
